// File: hw/rtl/b64e_pkg.sv
// Shared types, character codes and the symbol lookup for the base64 encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharLf  = 8'h0A;
  localparam logic [7:0] CharPad = 8'h3D;
  localparam logic [7:0] LineCharsReset = 8'd76;

  // One encoded group: four symbol indices, padding count, break and end flags
  typedef struct packed {
    logic [3:0][5:0] sym;
    logic [1:0]      npad;
    logic            crlf;
    logic            last;
  } grp_t;

  // Map a 6-bit index onto the standard base64 alphabet
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      sym_char = w + 8'd65;
    end else if (v < 6'd52) begin
      sym_char = w + 8'd71;
    end else if (v < 6'd62) begin
      sym_char = w - 8'd4;
    end else if (v == 6'd62) begin
      sym_char = 8'h2B;
    end else begin
      sym_char = 8'h2F;
    end
  endfunction

endpackage

// File: hw/rtl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder with line breaks.
// Depends on b64e_pkg, b64e_front, b64e_fifo and b64e_back.
//
//   word      direction  handshake                  payload
//   input     in         in_valid_i / in_ready_o    data_byte_i, last_byte_i
//   output    out        out_valid_o / out_ready_i  out_char_o, last_char_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_line_chars_i
//
// One character leaves per cycle from a registered output stage while the
// receiver is ready; three bytes give four characters, six with CR LF, and
// a padded remainder gives four characters. The front takes one byte per
// cycle but holds a group-completing byte while the two-entry group queue
// is full. A group is written into the queue, then its first character
// into the output register. Reset clears group phase, line count, queue
// and output valid; line length returns to 76. No stall loses a word.
`timescale 1ns / 1ps

module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_line_chars_i
);
  import b64e_pkg::*;

  logic [7:0] line_chars_q;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  grp_t       grp_in;
  grp_t       grp_head;

  // Hold the line length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_chars_q <= LineCharsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_chars_q <= cfg_line_chars_i;
    end
  end

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_chars_i (line_chars_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .full_i       (full),
    .push_o       (push),
    .grp_o        (grp_in)
  );

  b64e_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .grp_i   (grp_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .grp_o   (grp_head)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .grp_i       (grp_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("group queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid) else $error("group queue underflow");

  // CR is never the final character
  a_cr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_char_o == CharCr) |-> !last_char_o)
    else $error("message ends on CR");

  // LF follows a taken CR in the next cycle
  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_char_o == CharCr) |=>
    (out_valid_o && out_char_o == CharLf)) else $error("CR not followed by LF");

endmodule

// File: hw/rtl/b64e_front.sv
// Front end: gathers bytes into groups, tracks the line count and issues
// one group word per completed group or message end. Uses b64e_pkg.
`timescale 1ns / 1ps

module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        line_chars_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output b64e_pkg::grp_t    grp_o
);
  import b64e_pkg::*;

  logic [1:0][7:0] held_q, held_d;
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      line_q, line_d;
  logic            emit;
  logic            accept;
  logic [8:0]      cnt;
  logic            brk;

  // A group word goes out on the third byte or on the last byte
  assign emit       = (phase_q == 2'd2) || last_byte_i;
  assign in_ready_o = !full_i || !emit;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && emit;

  assign cnt = {1'b0, line_q} + 9'd4;
  assign brk = (line_chars_i != 8'd0) && (cnt >= {1'b0, line_chars_i});

  // Build the group word and the next group and line state
  always_comb begin
    grp_o   = '0;
    held_d  = held_q;
    phase_d = phase_q;
    line_d  = line_q;
    grp_o.last = last_byte_i;
    if (phase_q == 2'd2) begin
      grp_o.sym[0] = held_q[0][7:2];
      grp_o.sym[1] = {held_q[0][1:0], held_q[1][7:4]};
      grp_o.sym[2] = {held_q[1][3:0], data_byte_i[7:6]};
      grp_o.sym[3] = data_byte_i[5:0];
      grp_o.crlf   = brk;
      phase_d      = 2'd0;
      if (brk || (line_chars_i == 8'd0) || last_byte_i) begin
        line_d = 8'd0;
      end else begin
        line_d = cnt[7:0];
      end
    end else if (!last_byte_i) begin
      held_d[phase_q[0]] = data_byte_i;
      phase_d            = phase_q + 2'd1;
    end else begin
      if (phase_q == 2'd1) begin
        grp_o.sym[0] = held_q[0][7:2];
        grp_o.sym[1] = {held_q[0][1:0], data_byte_i[7:4]};
        grp_o.sym[2] = {data_byte_i[3:0], 2'b00};
        grp_o.npad   = 2'd1;
      end else begin
        grp_o.sym[0] = data_byte_i[7:2];
        grp_o.sym[1] = {data_byte_i[1:0], 4'b0000};
        grp_o.npad   = 2'd2;
      end
      phase_d = 2'd0;
      line_d  = 8'd0;
    end
  end

  // Hold group and line state; advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      phase_q <= 2'd0;
      line_q  <= 8'd0;
    end else if (accept) begin
      held_q  <= held_d;
      phase_q <= phase_d;
      line_q  <= line_d;
    end
  end

endmodule

// File: hw/rtl/b64e_fifo.sv
// Two-entry queue of group words between the front and back ends.
// Uses b64e_pkg for the entry type.
`timescale 1ns / 1ps

module b64e_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64e_pkg::grp_t    grp_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output b64e_pkg::grp_t    grp_o
);
  import b64e_pkg::*;

  grp_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign grp_o   = mem_q[rptr_q];

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= grp_i;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/b64e_back.sv
// Back end: walks the head group word, one character per cycle unless the
// output stalls, into a registered stage. Uses b64e_pkg types and lookup.
`timescale 1ns / 1ps

module b64e_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  b64e_pkg::grp_t    grp_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              last_char_o
);
  import b64e_pkg::*;

  logic [2:0] idx_q;
  logic       ovalid_q;
  logic [7:0] ochar_q;
  logic       olast_q;
  logic       load;
  logic       at_end;
  logic [2:0] end_idx;
  logic [7:0] chr;

  assign end_idx = grp_i.crlf ? 3'd5 : 3'd3;
  assign at_end  = idx_q == end_idx;
  assign load    = valid_i && (!ovalid_q || out_ready_i);
  assign pop_o   = load && at_end;

  // Pick the character at the current position
  always_comb begin
    case (idx_q)
      3'd4:    chr = CharCr;
      3'd5:    chr = CharLf;
      default: begin
        if (({1'b0, idx_q[1:0]} + {1'b0, grp_i.npad}) >= 3'd4) begin
          chr = CharPad;
        end else begin
          chr = sym_char(grp_i.sym[idx_q[1:0]]);
        end
      end
    endcase
  end

  // Advance the position and hold the output until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q    <= at_end ? 3'd0 : idx_q + 3'd1;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ochar_q <= chr;
      olast_q <= grp_i.last && at_end;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign last_char_o = olast_q;

endmodule
